@@ hw/rtl/exfat_esc_pkg.sv @@
// Shared types and constants of the exFAT entry set checker.
`default_nettype none

package exfat_esc_pkg;

  // Size of one directory entry in bytes, and its log2.
  localparam int unsigned ENTRY_BYTES = 32;
  localparam int unsigned ENTRY_SHIFT = 5;

  // Byte position counter width: covers (255 + 1) * ENTRY_BYTES positions.
  localparam int unsigned POS_W = 13;

  localparam logic [POS_W-1:0] POS_TYPE0    = '0;
  localparam logic [POS_W-1:0] POS_COUNT    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SUM_LO   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SUM_HI   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_STREAM   = POS_W'(ENTRY_BYTES);
  localparam logic [POS_W-1:0] POS_NAME     = POS_W'(2 * ENTRY_BYTES);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_TYPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEC      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEC      = 3'd4;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_TYPE     = 2'd1;
  localparam logic [1:0] VERDICT_COUNT    = 2'd2;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd3;

  typedef struct packed {
    logic [7:0] primary_type_code;
    logic [7:0] stream_type_code;
    logic [7:0] name_type_code;
    logic [7:0] min_secondaries;
    logic [7:0] max_secondaries;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] computed_sum;
    logic [15:0] stored_sum;
    logic [7:0]  secondary_count;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/exfat_esc_cfg.sv @@
// Configuration registers of the exFAT entry set checker.
`default_nettype none

module exfat_esc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [exfat_esc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                           cfg_wdata_i,
  output exfat_esc_pkg::cfg_t                  cfg_o
);
  import exfat_esc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRIMARY_TYPE: cfg_d.primary_type_code = cfg_wdata_i;
        CFG_STREAM_TYPE:  cfg_d.stream_type_code  = cfg_wdata_i;
        CFG_NAME_TYPE:    cfg_d.name_type_code    = cfg_wdata_i;
        CFG_MIN_SEC:      cfg_d.min_secondaries   = cfg_wdata_i;
        CFG_MAX_SEC:      cfg_d.max_secondaries   = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.primary_type_code <= 8'h85;
      cfg_q.stream_type_code  <= 8'hC0;
      cfg_q.name_type_code    <= 8'hC1;
      cfg_q.min_secondaries   <= 8'd2;
      cfg_q.max_secondaries   <= 8'd18;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/exfat_esc_core.sv @@
// Per-byte check and rotate-add checksum step with its set state.
`default_nettype none

module exfat_esc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   set_start_i,
  input  exfat_esc_pkg::cfg_t    cfg_i,
  output logic                   res_valid_o,
  output exfat_esc_pkg::result_t res_o
);
  import exfat_esc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      exp_q, exp_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             tf_q, tf_d;
  logic             active_q, active_d;

  logic [POS_W-1:0] pos;
  logic [15:0]      sum_base, exp_base;
  logic [7:0]       cnt_base;
  logic             tf_base;
  logic             live;
  logic [POS_W-1:0] last_pos;
  logic             at_name;
  logic             have_verdict;
  logic [1:0]       verdict;

  always_comb begin
    // A start flag wipes the set state for this very byte.
    pos      = set_start_i ? '0 : pos_q;
    sum_base = set_start_i ? '0 : sum_q;
    exp_base = set_start_i ? '0 : exp_q;
    cnt_base = set_start_i ? '0 : cnt_q;
    tf_base  = set_start_i ? 1'b0 : tf_q;
    live     = set_start_i | active_q;

    cnt_d = (pos == POS_COUNT) ? data_byte_i : cnt_base;

    exp_d = exp_base;
    sum_d = sum_base;
    if (pos == POS_SUM_LO) begin
      exp_d = {exp_base[15:8], data_byte_i};
    end else if (pos == POS_SUM_HI) begin
      exp_d = {data_byte_i, exp_base[7:0]};
    end else if (pos[POS_W-1:ENTRY_SHIFT] <= cnt_d) begin
      // Inside the covered range: rotate right by one, then add the byte.
      sum_d = {sum_base[0], sum_base[15:1]} + {8'h00, data_byte_i};
    end

    tf_d = tf_base
         | ((pos == POS_TYPE0)  && (data_byte_i != cfg_i.primary_type_code))
         | ((pos == POS_STREAM) && (data_byte_i != cfg_i.stream_type_code))
         | ((pos == POS_NAME)   && (data_byte_i != cfg_i.name_type_code));

    // Last covered byte is count * ENTRY_BYTES + ENTRY_BYTES - 1.
    last_pos = {cnt_d, {ENTRY_SHIFT{1'b1}}};
    at_name  = (pos == POS_NAME);

    have_verdict = 1'b1;
    verdict      = VERDICT_OK;
    if (at_name && tf_d) begin
      verdict = VERDICT_TYPE;
    end else if (at_name && ((cnt_d < cfg_i.min_secondaries) ||
                             (cnt_d > cfg_i.max_secondaries))) begin
      verdict = VERDICT_COUNT;
    end else if ((pos >= POS_NAME) && (pos >= last_pos)) begin
      verdict = (sum_d == exp_d) ? VERDICT_OK : VERDICT_MISMATCH;
    end else begin
      have_verdict = 1'b0;
    end

    pos_d    = have_verdict ? pos : pos + POS_W'(1);
    active_d = ~have_verdict;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      exp_q    <= '0;
      cnt_q    <= '0;
      tf_q     <= 1'b0;
      active_q <= 1'b0;
    end else if (step_i && live) begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      exp_q    <= exp_d;
      cnt_q    <= cnt_d;
      tf_q     <= tf_d;
      active_q <= active_d;
    end
  end

  assign res_valid_o           = step_i & live & have_verdict;
  assign res_o.verdict         = verdict;
  assign res_o.computed_sum    = sum_d;
  assign res_o.stored_sum      = exp_d;
  assign res_o.secondary_count = cnt_d;

endmodule

`default_nettype wire

@@ hw/rtl/exfat_entry_set_checker.sv @@
// Top level of the exFAT directory entry set checker.
`default_nettype none

// Takes one byte of an exFAT entry set per request, with set_start_i on byte 0,
// and gives at most one verdict request per set: bad type byte at offsets 0, 32
// or 64, continuation count outside [min, max], or the rotate-right-and-add
// checksum against the stored one. It accepts one byte every cycle while the
// output side is not stalled; a byte passes an input register and the checksum
// and check logic, and a verdict lands in the result register. The per-byte
// rotate-add into the running sum is the loop that sets the one-byte-per-cycle
// rate. Configuration writes take effect at once and are meant for idle time.

module exfat_entry_set_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        set_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [15:0] computed_sum_o,
  output logic [15:0] stored_sum_o,
  output logic [7:0]  secondary_count_o
);
  import exfat_esc_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;
  logic       in_accept;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // The staged byte moves on whenever the result register can take a result.
  assign advance   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept = in_valid_i & ~in_stall_o;

  exfat_esc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  exfat_esc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q & advance),
    .data_byte_i (byte_q),
    .set_start_i (start_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept || advance) begin
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= data_byte_i;
      start_q <= set_start_i;
    end
  end

  assign out_valid_d = advance ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = out_q.verdict;
  assign computed_sum_o    = out_q.computed_sum;
  assign stored_sum_o      = out_q.stored_sum;
  assign secondary_count_o = out_q.secondary_count;

endmodule

`default_nettype wire

@@ bench/exfat_entry_set_checker_tb.sv @@
// Testbench of the exFAT entry set checker: per-byte verdict prediction, directed and random sets.
`default_nettype none

module exfat_entry_set_checker_tb;
  import exfat_esc_pkg::*;

  typedef logic [7:0] byte_list_t [];

  localparam int IDLE_PCT       = 13;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int RANDOM_BYTES   = 1100;
  localparam int RANDOM_RESULTS = 40;
  localparam int SETS_PER_PHASE = 10;
  localparam cfg_t RESET_CFG    = '{8'h85, 8'hC0, 8'hC1, 8'd2, 8'd18};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic                 set_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           verdict_o;
  logic [15:0]          computed_sum_o;
  logic [15:0]          stored_sum_o;
  logic [7:0]           secondary_count_o;

  exfat_entry_set_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .set_start_i       (set_start_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .verdict_o         (verdict_o),
    .computed_sum_o    (computed_sum_o),
    .stored_sum_o      (stored_sum_o),
    .secondary_count_o (secondary_count_o)
  );

  // Shadow of the configuration and of the per-set checking state.
  cfg_t        cfg_now = RESET_CFG;
  bit          set_open = 1'b0;
  logic [POS_W-1:0] pos_now = '0;
  logic [15:0] sum_now = '0;
  logic [15:0] stored_now = '0;
  logic [7:0]  count_now = '0;
  bit          type_bad = 1'b0;

  result_t verdicts_due [$];
  int      fail_count = 0;
  int      results_seen = 0;
  int      set_bytes_sent = 0;
  int      idle_pct = IDLE_PCT;
  int      cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
               verdicts_due.size());
      $display("** exfat_entry_set_checker: FAILED **");
      $finish;
    end
  end

  // Mirrors the block for one accepted byte and queues the verdict it causes, if any.
  function automatic void track_entry_byte(input logic [7:0] b, input logic s);
    int unsigned p;
    int unsigned covered;
    logic [1:0]  v;
    bit          give;
    result_t     r;
    if (s) begin
      set_open   = 1'b1;
      pos_now    = '0;
      sum_now    = '0;
      stored_now = '0;
      count_now  = '0;
      type_bad   = 1'b0;
    end
    if (!set_open) return;
    p = pos_now;
    if (pos_now == POS_COUNT) count_now = b;
    covered = (int'(count_now) + 1) * ENTRY_BYTES;
    if (pos_now == POS_SUM_LO) stored_now[7:0] = b;
    else if (pos_now == POS_SUM_HI) stored_now[15:8] = b;
    else if (p < covered) sum_now = {sum_now[0], sum_now[15:1]} + 16'(b);
    if ((pos_now == POS_TYPE0 && b != cfg_now.primary_type_code) ||
        (pos_now == POS_STREAM && b != cfg_now.stream_type_code) ||
        (pos_now == POS_NAME && b != cfg_now.name_type_code))
      type_bad = 1'b1;
    give = 1'b1;
    v = VERDICT_OK;
    if (pos_now == POS_NAME && type_bad) v = VERDICT_TYPE;
    else if (pos_now == POS_NAME && (count_now < cfg_now.min_secondaries ||
                                     count_now > cfg_now.max_secondaries))
      v = VERDICT_COUNT;
    else if (p >= POS_NAME && p >= covered - 1)
      v = (sum_now == stored_now) ? VERDICT_OK : VERDICT_MISMATCH;
    else give = 1'b0;
    if (!give) begin
      pos_now = pos_now + 1'b1;
      return;
    end
    set_open          = 1'b0;
    r.verdict         = v;
    r.computed_sum    = sum_now;
    r.stored_sum      = stored_now;
    r.secondary_count = count_now;
    verdicts_due = {verdicts_due, r};
  endfunction

  function automatic logic [15:0] checksum_of(input byte_list_t set_bytes, input int covered);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < covered; i++)
      if (i != int'(POS_SUM_LO) && i != int'(POS_SUM_HI))
        acc = {acc[0], acc[15:1]} + 16'(set_bytes[i]);
    return acc;
  endfunction

  // Result side: random stall, and each accepted verdict against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    out_stall_i <= ($urandom_range(99) < idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {verdict_o, computed_sum_o, stored_sum_o, secondary_count_o};
      results_seen++;
      if (verdicts_due.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected verdict %0d sum %h stored %h count %0d", got.verdict,
                   got.computed_sum, got.stored_sum, got.secondary_count);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("mismatch: verdict %0d/%0d sum %h/%h stored %h/%h count %0d/%0d (exp/got)",
                     want.verdict, got.verdict, want.computed_sum, got.computed_sum,
                     want.stored_sum, got.stored_sum, want.secondary_count,
                     got.secondary_count);
          fail_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    set_start_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    track_entry_byte(b, s);
  endtask

  // Waits until every predicted verdict has come and the pipeline has emptied.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PRIMARY_TYPE: cfg_now.primary_type_code = val;
      CFG_STREAM_TYPE:  cfg_now.stream_type_code  = val;
      CFG_NAME_TYPE:    cfg_now.name_type_code    = val;
      CFG_MIN_SEC:      cfg_now.min_secondaries   = val;
      CFG_MAX_SEC:      cfg_now.max_secondaries   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_PRIMARY_TYPE, c.primary_type_code);
    write_reg(CFG_STREAM_TYPE, c.stream_type_code);
    write_reg(CFG_NAME_TYPE, c.name_type_code);
    write_reg(CFG_MIN_SEC, c.min_secondaries);
    write_reg(CFG_MAX_SEC, c.max_secondaries);
  endtask

  // Sends one entry set built from the current codes. A bad type flips the byte at the given
  // offset; a cut stops after that many bytes so that the next start flag restarts the check.
  task automatic send_entry_set(input int count, input int bad_type_at, input bit bad_sum,
                                input int cut_at);
    byte_list_t  set_bytes;
    int          covered;
    int          body;
    int          trail;
    bit          faulty;
    logic [15:0] check_word;
    covered = (count + 1) * ENTRY_BYTES;
    body = (covered > int'(POS_NAME) + 1) ? covered : int'(POS_NAME) + 1;
    set_bytes = new[body + 3];
    foreach (set_bytes[i]) set_bytes[i] = 8'($urandom_range(255));
    set_bytes[POS_TYPE0]  = cfg_now.primary_type_code;
    set_bytes[POS_COUNT]  = 8'(count);
    set_bytes[POS_STREAM] = cfg_now.stream_type_code;
    set_bytes[POS_NAME]   = cfg_now.name_type_code;
    if (bad_type_at >= 0) set_bytes[bad_type_at] ^= 8'($urandom_range(1, 255));
    check_word = checksum_of(set_bytes, covered);
    if (bad_sum) check_word ^= 16'($urandom_range(1, 65535));
    set_bytes[POS_SUM_LO] = check_word[7:0];
    set_bytes[POS_SUM_HI] = check_word[15:8];
    faulty = (bad_type_at >= 0) || (count < cfg_now.min_secondaries) ||
             (count > cfg_now.max_secondaries);
    // A faulty set is judged at byte 64; whatever follows is ignored, so keep it short.
    if (faulty) body = int'(POS_NAME) + 1;
    trail = $urandom_range(3);
    if (cut_at >= 0) begin
      body  = cut_at;
      trail = 0;
    end
    for (int i = 0; i < body + trail; i++) send_byte(set_bytes[i], i == 0);
    set_bytes_sent += body;
  endtask

  task automatic test_default_sets();
    send_entry_set(2, -1, 1'b0, -1);
    send_entry_set(2, -1, 1'b1, -1);
    send_entry_set(18, -1, 1'b0, -1);
    send_entry_set(5, -1, 1'b1, -1);
  endtask

  task automatic test_type_checks();
    send_entry_set(3, int'(POS_TYPE0), 1'b0, -1);
    send_entry_set(3, int'(POS_STREAM), 1'b0, -1);
    send_entry_set(3, int'(POS_NAME), 1'b1, -1);
    // The type fault wins over a count that is out of range as well.
    send_entry_set(1, int'(POS_TYPE0), 1'b0, -1);
    send_entry_set(200, int'(POS_NAME), 1'b0, -1);
  endtask

  task automatic test_count_limits();
    cfg_t c;
    send_entry_set(1, -1, 1'b0, -1);
    send_entry_set(19, -1, 1'b0, -1);
    send_entry_set(0, -1, 1'b0, -1);
    wait_idle();
    c = RESET_CFG;
    c.min_secondaries = 8'd0;
    c.max_secondaries = 8'd1;
    load_config(c);
    // Short sets end before byte 64, so the verdict waits for the third type byte.
    send_entry_set(0, -1, 1'b0, -1);
    send_entry_set(1, -1, 1'b0, -1);
    send_entry_set(1, -1, 1'b1, -1);
    send_entry_set(0, -1, 1'b1, -1);
    send_entry_set(2, -1, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_crossed_limits();
    cfg_t c;
    c = RESET_CFG;
    c.min_secondaries = 8'd9;
    c.max_secondaries = 8'd3;
    load_config(c);
    send_entry_set(5, -1, 1'b0, -1);
    send_entry_set(9, -1, 1'b0, -1);
    send_entry_set(3, -1, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_extreme_codes();
    load_config('{8'h00, 8'h00, 8'h00, 8'd0, 8'd255});
    send_entry_set(0, -1, 1'b0, -1);
    send_entry_set(2, int'(POS_STREAM), 1'b0, -1);
    wait_idle();
    load_config('{8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd255});
    send_entry_set(255, -1, 1'b0, -1);
    send_entry_set(254, -1, 1'b0, -1);
    wait_idle();
    load_config(RESET_CFG);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(RESET_CFG.primary_type_code, 1'b0);
    send_entry_set(2, -1, 1'b0, int'(POS_COUNT));
    send_entry_set(2, -1, 1'b0, int'(POS_SUM_HI));
    send_entry_set(3, -1, 1'b0, 40);
    send_entry_set(2, -1, 1'b0, int'(POS_NAME));
    send_entry_set(2, -1, 1'b0, -1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_entry_set(4, -1, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_unused_index();
    for (int i = int'(CFG_MAX_SEC) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 8'($urandom_range(255)));
    send_entry_set(2, -1, 1'b0, -1);
    send_entry_set(19, -1, 1'b0, -1);
    wait_idle();
  endtask

  task automatic pick_random_config(input int phase);
    cfg_t c;
    c.primary_type_code = 8'($urandom_range(255));
    c.stream_type_code  = 8'($urandom_range(255));
    c.name_type_code    = 8'($urandom_range(255));
    c.min_secondaries   = 8'($urandom_range(3));
    c.max_secondaries   = c.min_secondaries + 8'($urandom_range(5));
    if (phase % 5 == 4) begin
      c.min_secondaries = 8'($urandom_range(4, 255));
      c.max_secondaries = 8'($urandom_range(0, int'(c.min_secondaries) - 1));
    end
    load_config(c);
  endtask

  task automatic test_random_traffic();
    int phase;
    int bytes_at_start;
    int results_at_start;
    int pick;
    int lo;
    int hi;
    int span;
    int count;
    int covered;
    phase = 0;
    bytes_at_start = set_bytes_sent;
    results_at_start = results_seen;
    while (set_bytes_sent - bytes_at_start < RANDOM_BYTES ||
           results_seen - results_at_start < RANDOM_RESULTS) begin
      wait_idle();
      pick_random_config(phase);
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      lo = cfg_now.min_secondaries;
      hi = cfg_now.max_secondaries;
      for (int n = 0; n < SETS_PER_PHASE; n++) begin
        span = (hi > lo) ? hi - lo : 0;
        if (span > 3 && $urandom_range(14) != 0) span = 3;
        if (span > 30) span = 30;
        count = lo + $urandom_range(span);
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_entry_set(count, -1, 1'b0, -1);
        end else if (pick < 57) begin
          send_entry_set(count, -1, 1'b1, -1);
        end else if (pick < 67) begin
          send_entry_set(count, ENTRY_BYTES * $urandom_range(2), $urandom_range(1), -1);
        end else if (pick < 77) begin
          if (lo > 0 && ($urandom_range(1) == 1 || hi >= 255)) count = $urandom_range(lo - 1);
          else if (hi < 255) count = $urandom_range(hi + 1, (hi + 20 > 255) ? 255 : hi + 20);
          send_entry_set(count, -1, 1'b0, -1);
        end else if (pick < 90) begin
          covered = (count + 1) * ENTRY_BYTES;
          if (covered < int'(POS_NAME) + 1) covered = int'(POS_NAME) + 1;
          send_entry_set(count, -1, 1'b0, $urandom_range(1, covered - 1));
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
        end
      end
      // Close the phase with a complete set so that no check is left open.
      send_entry_set(lo + $urandom_range((hi > lo) ? 1 : 0), -1, 1'b0, -1);
      phase++;
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_sets();
    test_type_checks();
    test_count_limits();
    test_crossed_limits();
    test_extreme_codes();
    test_ignored_bytes();
    test_unused_index();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0 && verdicts_due.size() == 0)
      $display("** exfat_entry_set_checker: PASSED **");
    else
      $display("** exfat_entry_set_checker: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

@@ exfat_entry_set_checker.f @@
hw/rtl/exfat_esc_pkg.sv
hw/rtl/exfat_esc_cfg.sv
hw/rtl/exfat_esc_core.sv
hw/rtl/exfat_entry_set_checker.sv
bench/exfat_entry_set_checker_tb.sv
